>>> hw/rtl/ldhf_pkg.sv
// Shared types and constants of the line deduplication hash filter.
// Used by ldhf_front, ldhf_back, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ldhf_pkg;

    localparam logic [63:0] HASH_SEED  = 64'd5381;
    localparam int          HASH_SHIFT = 5;
    localparam logic [7:0]  BYTE_CR    = 8'h0D;
    localparam logic [7:0]  BYTE_LF    = 8'h0A;
    localparam logic [15:0] LEN_MAX    = 16'hFFFF;

    localparam logic        MODE_DATA  = 1'b0;
    localparam logic        MODE_CLEAR = 1'b1;

    localparam logic [1:0]  ST_NEW  = 2'd0;
    localparam logic [1:0]  ST_DUP  = 2'd1;
    localparam logic [1:0]  ST_FULL = 2'd2;

    localparam int          CMDQ_DEPTH = 4;
    localparam int          CMDQ_AW    = 2;
    localparam int          SLOT_W     = 65;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] line_hash;
        logic [15:0] line_length;
    } t_out_item;

    typedef struct packed {
        logic        is_clear;
        logic [63:0] hash;
        logic [15:0] length;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

endpackage

`default_nettype wire

>>> hw/rtl/ldhf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module ldhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/ldhf_front.sv
// Front part: running djb2 hash and line length, and the command queue.
// Depends on ldhf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldhf_front
    import ldhf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_item  i_item,
    output logic           o_full,
    output t_cmd_head      o_head,
    input  wire logic      i_head_pop
);

    logic [63:0]        r_hash, n_hash;
    logic [15:0]        r_len, n_len;
    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, r_rp;
    logic [CMDQ_AW:0]   r_cnt;
    logic               w_enq;
    t_cmd               w_enq_cmd;
    logic [15:0]        w_len_inc;
    logic [63:0]        w_ext;

    assign w_len_inc = (r_len == LEN_MAX) ? r_len : r_len + 16'd1;
    assign w_ext     = {{56{i_item.data_byte[7]}}, i_item.data_byte};

    always_comb begin
        n_hash    = r_hash;
        n_len     = r_len;
        w_enq     = 1'b0;
        w_enq_cmd = '{is_clear: 1'b0, hash: r_hash, length: w_len_inc};
        if (i_accept) begin
            if (i_item.mode == MODE_CLEAR) begin
                w_enq              = 1'b1;
                w_enq_cmd.is_clear = 1'b1;
                n_hash             = HASH_SEED;
                n_len              = '0;
            end else begin
                n_len = w_len_inc;
                if (i_item.data_byte == BYTE_LF) begin
                    w_enq  = 1'b1;
                    n_hash = HASH_SEED;
                    n_len  = '0;
                end else if (i_item.data_byte != BYTE_CR) begin
                    n_hash = (r_hash << HASH_SHIFT) + r_hash + w_ext;
                end
                if (i_item.chunk_end) begin
                    n_hash = HASH_SEED;
                    n_len  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_SEED;
            r_len  <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_hash <= n_hash;
            r_len  <= n_len;
            if (w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_head_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (CMDQ_AW+1)'(w_enq) - (CMDQ_AW+1)'(i_head_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_enq_cmd;
        end
    end

    assign o_full       = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

`default_nettype wire

>>> hw/rtl/ldhf_back.sv
// Back part: clearing sweeps, hash reduction, linear probe walk and result register.
// Depends on ldhf_pkg and ldhf_ram.
`timescale 1ns / 1ps
`default_nettype none

module ldhf_back
    import ldhf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_PROBES    = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd_head  i_head,
    output logic            o_head_pop,
    output logic            o_init,
    output logic            o_out_valid,
    output t_out_item       o_out,
    input  wire logic       i_out_pop
);

    localparam int AW       = $clog2(TABLE_ENTRIES);
    localparam int LIMIT    = (MAX_PROBES > TABLE_ENTRIES) ? TABLE_ENTRIES : MAX_PROBES;
    localparam int CW       = $clog2(LIMIT + 1);
    localparam bit IS_POW2  = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam logic [AW-1:0] LAST_POS = AW'(TABLE_ENTRIES - 1);
    localparam int RECIP    = (1 << 28) / TABLE_ENTRIES;

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_rem, n_rem;
    logic [2:0]        r_idx, n_idx;
    logic              r_phase, n_phase;
    logic [AW+7:0]     r_t, n_t;
    logic [8:0]        r_quo, n_quo;
    logic [63:0]       r_key, n_key;
    logic [15:0]       r_len, n_len;
    logic              r_init, n_init;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic              w_we;
    logic [SLOT_W-1:0] w_wdata;
    logic [SLOT_W-1:0] w_rdata;
    logic [AW+7:0]     w_mod_t;
    logic [36:0]       w_prod;
    logic [AW+7:0]     w_qn;
    logic [AW+7:0]     w_r1;
    logic [AW+7:0]     w_r1_sub;
    logic [AW-1:0]     w_rem_next;

    // The key is reduced one byte at a time: the quotient of each partial remainder
    // is estimated with a reciprocal and is at most one short, so one subtract ends it.
    assign w_mod_t    = {r_rem, r_key[{~r_idx, 3'b000} +: 8]};
    assign w_prod     = 37'(w_mod_t) * 37'(RECIP);
    assign w_qn       = (AW+8)'(r_quo) * (AW+8)'(TABLE_ENTRIES);
    assign w_r1       = r_t - w_qn;
    assign w_r1_sub   = w_r1 - (AW+8)'(TABLE_ENTRIES);
    assign w_rem_next = (w_r1 >= (AW+8)'(TABLE_ENTRIES)) ? w_r1_sub[AW-1:0]
                                                         : w_r1[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_t         = r_t;
        n_quo       = r_quo;
        n_key       = r_key;
        n_len       = r_len;
        n_init      = r_init;
        n_out_valid = r_out_valid & ~i_out_pop;
        n_out       = r_out;
        w_we        = 1'b0;
        w_wdata     = '0;
        o_head_pop  = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                w_we = 1'b1;
                if (r_pos == LAST_POS) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.cmd.is_clear) begin
                        o_head_pop = 1'b1;
                        n_pos      = '0;
                        n_state    = S_SWEEP;
                    end else if (!r_out_valid) begin
                        o_head_pop = 1'b1;
                        n_key      = i_head.cmd.hash;
                        n_len      = i_head.cmd.length;
                        n_cnt      = '0;
                        if (IS_POW2) begin
                            n_pos   = i_head.cmd.hash[AW-1:0];
                            n_state = S_PROBE;
                        end else begin
                            n_rem   = '0;
                            n_idx   = '0;
                            n_phase = 1'b0;
                            n_state = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                if (!r_phase) begin
                    n_t     = w_mod_t;
                    n_quo   = w_prod[36:28];
                    n_phase = 1'b1;
                end else begin
                    n_rem   = w_rem_next;
                    n_idx   = r_idx + 3'd1;
                    n_phase = 1'b0;
                    if (r_idx == 3'd7) begin
                        n_pos   = w_rem_next;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_out.line_hash   = r_key;
                n_out.line_length = r_len;
                if (!w_rdata[SLOT_W-1]) begin
                    w_we         = 1'b1;
                    w_wdata      = {1'b1, r_key};
                    n_out.status = ST_NEW;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else if (w_rdata[63:0] == r_key) begin
                    n_out.status = ST_DUP;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_cnt == CW'(LIMIT - 1)) begin
                    n_out.status = ST_FULL;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_pos = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_pos       <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_idx   <= n_idx;
        r_phase <= n_phase;
        r_t     <= n_t;
        r_quo   <= n_quo;
        r_key   <= n_key;
        r_len   <= n_len;
        r_out   <= n_out;
    end

    ldhf_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_pos),
        .i_wdata(w_wdata),
        .i_raddr(n_pos),
        .o_rdata(w_rdata)
    );

    assign o_init      = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/line_dedup_hash_filter_top.sv
// Top level of the line deduplication hash filter.
// Depends on ldhf_pkg, ldhf_front, ldhf_back and ldhf_ram.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          i_in_data  (t_in_item)
//   result    out        pop / empty          o_out_data (t_out_item)
//
// The front hashes each accepted byte; a line feed or clear joins a four-entry queue.
// A line lookup walks up to MAX_PROBES slots of the slot RAM in a linear probe, after a
// byte-wise hash reduction when TABLE_ENTRIES is not a power of two.
// A clear item sweeps every slot of the slot RAM while bytes keep flowing.
// After reset, full stays high while the slot RAM is swept.
// full rises when the queue is full; a waiting result holds back further lookups.
`timescale 1ns / 1ps
`default_nettype none

module line_dedup_hash_filter_top
    import ldhf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_PROBES    = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_in_data,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_out_data
);

    logic      w_q_full;
    logic      w_init;
    logic      w_accept;
    t_cmd_head w_head;
    logic      w_head_pop;
    logic      w_out_valid;

    assign full     = w_q_full | w_init;
    assign w_accept = push & ~full;
    assign empty    = ~w_out_valid;

    ldhf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (i_in_data),
        .o_full    (w_q_full),
        .o_head    (w_head),
        .i_head_pop(w_head_pop)
    );

    ldhf_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_PROBES   (MAX_PROBES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_head_pop (w_head_pop),
        .o_init     (w_init),
        .o_out_valid(w_out_valid),
        .o_out      (o_out_data),
        .i_out_pop  (pop & ~empty)
    );

    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> full)
        else $error("Input transfer possible during the slot clearing sweep.");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head_pop |-> w_head.valid)
        else $error("Command queue popped while empty.");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_data.status == ST_NEW || o_out_data.status == ST_DUP ||
                    o_out_data.status == ST_FULL))
        else $error("Result carries an undefined status code.");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for line_dedup_hash_filter_top: byte streams are driven into the
// filter and each line result is compared with an in-bench model of the hash set.
// Depends on ldhf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_top;
    import ldhf_pkg::*;

    localparam int TBL_SLOTS     = 4096;
    localparam int PROBE_LIMIT   = 16;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int CROWD_LINES   = 40;
    localparam int HOLD_AT       = 60;
    localparam int LONG_HOLD     = 600;
    localparam int STALL_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 100;
    localparam int MAX_PRINTS    = 100;

    typedef struct {
        t_in_item item;
        int       gap;
    } t_stim;

    typedef struct {
        logic [7:0] txt [16];
        int         len;
    } t_line;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      push       = 1'b0;
    logic      pop        = 1'b0;
    t_in_item  i_in_data  = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_data;

    t_stim     pending [$];
    t_out_item expected_lines [$];
    t_stim     staged;
    logic      have_staged = 1'b0;
    int        fed_count    = 0;
    int        total_items  = 0;
    int        results_seen = 0;
    int        err_count    = 0;
    int        pop_wait     = 0;
    int        idle_cycles  = 0;
    logic      tx_calm      = 1'b0;
    logic      rx_calm      = 1'b0;

    // Model state of the filter.
    logic [63:0] cur_hash = HASH_SEED;
    logic [15:0] cur_len  = '0;
    logic        slot_used [TBL_SLOTS];
    logic [63:0] slot_key  [TBL_SLOTS];

    line_dedup_hash_filter_top #(
        .TABLE_ENTRIES (TBL_SLOTS),
        .MAX_PROBES    (PROBE_LIMIT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_data  (i_in_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] djb2_next(logic [63:0] h, logic [7:0] b);
        return (h << HASH_SHIFT) + h + {{56{b[7]}}, b};
    endfunction

    function automatic logic [1:0] probe_set(logic [63:0] key);
        int limit;
        int pos;
        limit = (PROBE_LIMIT > TBL_SLOTS) ? TBL_SLOTS : PROBE_LIMIT;
        pos = int'(key % 64'(TBL_SLOTS));
        for (int n = 0; n < limit; n++) begin
            if (!slot_used[pos]) begin
                slot_used[pos] = 1'b1;
                slot_key[pos] = key;
                return ST_NEW;
            end
            if (slot_key[pos] == key) return ST_DUP;
            pos = (pos + 1) % TBL_SLOTS;
        end
        return ST_FULL;
    endfunction

    task automatic predict_item(t_in_item it);
        t_out_item res;
        if (it.mode == MODE_CLEAR) begin
            foreach (slot_used[k]) slot_used[k] = 1'b0;
            cur_hash = HASH_SEED;
            cur_len = '0;
            return;
        end
        if (cur_len != LEN_MAX) cur_len++;
        if (it.data_byte == BYTE_LF) begin
            res.status = probe_set(cur_hash);
            res.line_hash = cur_hash;
            res.line_length = cur_len;
            expected_lines.push_back(res);
            cur_hash = HASH_SEED;
            cur_len = '0;
        end else if (it.data_byte != BYTE_CR) begin
            cur_hash = djb2_next(cur_hash, it.data_byte);
        end
        if (it.chunk_end) begin
            cur_hash = HASH_SEED;
            cur_len = '0;
        end
    endtask

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("tb_top: mismatch: %s", msg);
    endtask

    task automatic check_line_result(t_out_item got);
        t_out_item want;
        if (expected_lines.size() == 0) begin
            flag_error($sformatf("result with nothing expected, hash %h", got.line_hash));
            return;
        end
        want = expected_lines.pop_front();
        if (got.status !== want.status)
            flag_error($sformatf("status %0d, expected %0d (hash %h)",
                                 got.status, want.status, want.line_hash));
        if (got.line_hash !== want.line_hash)
            flag_error($sformatf("hash %h, expected %h", got.line_hash, want.line_hash));
        if (got.line_length !== want.line_length)
            flag_error($sformatf("length %0d, expected %0d (hash %h)",
                                 got.line_length, want.line_length, want.line_hash));
    endtask

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        return tx_calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic queue_data(logic [7:0] b, logic ce, int gap);
        t_stim s;
        s.item = '{mode: MODE_DATA, data_byte: b, chunk_end: ce};
        s.gap = gap;
        pending.push_back(s);
    endtask

    task automatic queue_clear(logic [7:0] b, logic ce);
        t_stim s;
        s.item = '{mode: MODE_CLEAR, data_byte: b, chunk_end: ce};
        s.gap = draw_gap();
        pending.push_back(s);
    endtask

    task automatic queue_line(t_line ln, logic with_cr, logic ce_on_lf, logic no_gap);
        for (int k = 0; k < ln.len; k++) queue_data(ln.txt[k], 1'b0, no_gap ? 0 : draw_gap());
        if (with_cr) queue_data(BYTE_CR, 1'b0, no_gap ? 0 : draw_gap());
        queue_data(BYTE_LF, ce_on_lf, no_gap ? 0 : draw_gap());
    endtask

    function automatic t_line rand_line();
        t_line ln;
        ln.len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
        for (int k = 0; k < 16; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                ln.txt[k] = BYTE_CR;
            end else begin
                do ln.txt[k] = 8'($urandom_range(0, 255)); while (ln.txt[k] == BYTE_LF);
            end
        end
        return ln;
    endfunction

    // Sender: offers queued items and updates the model on every accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            have_staged = 1'b0;
        end else begin
            if (push && !full) begin
                predict_item(i_in_data);
                fed_count++;
            end
            if (!push || !full) begin
                if (!have_staged && pending.size() != 0) begin
                    staged = pending.pop_front();
                    have_staged = 1'b1;
                end
                if (have_staged && staged.gap > 0) begin
                    staged.gap--;
                    push <= 1'b0;
                end else if (have_staged) begin
                    i_in_data <= staged.item;
                    push <= 1'b1;
                    have_staged = 1'b0;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer, then waits a drawn number of cycles, or a long hold after result HOLD_AT.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_wait = 0;
        end else begin
            if (pop && !empty) begin
                check_line_result(o_out_data);
                results_seen++;
                if (results_seen == HOLD_AT) begin
                    pop_wait = LONG_HOLD;
                end else begin
                    if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
                    pop_wait = rx_calm ? 0 : $urandom_range(0, 10);
                end
            end
            if (pop_wait > 0) begin
                pop_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0]  extreme_bytes [4];
        t_line       ln;
        t_line       history [$];
        t_line       crowd [$];
        logic [63:0] h;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        int          target;
        int          rr;
        int          a0;
        int          start_n;
        int          pick;
        int          crowd_idx;

        foreach (slot_used[k]) slot_used[k] = 1'b0;
        extreme_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};

        // Extreme bytes with sign extension, then the same text as a duplicate, then two empty lines.
        foreach (extreme_bytes[k]) queue_data(extreme_bytes[k], 1'b0, draw_gap());
        queue_data(BYTE_CR, 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b0, draw_gap());
        foreach (extreme_bytes[k]) queue_data(extreme_bytes[k], 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b0, draw_gap());
        queue_data(BYTE_CR, 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b0, draw_gap());
        // A partial line cut by a chunk end, then a line whose line feed ends the chunk.
        queue_data("x", 1'b0, draw_gap());
        queue_data("y", 1'b0, draw_gap());
        queue_data("z", 1'b1, draw_gap());
        queue_data("q", 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b1, draw_gap());
        // A clear in the middle of a line; its byte and chunk end fields are ignored.
        queue_data("a", 1'b0, draw_gap());
        queue_clear(BYTE_LF, 1'b1);
        queue_data("c", 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b0, draw_gap());
        foreach (extreme_bytes[k]) queue_data(extreme_bytes[k], 1'b0, draw_gap());
        queue_data(BYTE_LF, 1'b0, draw_gap());

        // Three-byte lines that all start their walk at one slot, to exhaust the probes.
        target = $urandom_range(0, TBL_SLOTS - 1);
        a0 = $urandom_range(0, 255);
        for (int i = 0; i < 256 && crowd.size() < CROWD_LINES; i++) begin
            a = 8'(a0 + i);
            if (a == BYTE_CR || a == BYTE_LF) continue;
            for (int j = 0; j < 256 && crowd.size() < CROWD_LINES; j++) begin
                b = 8'(j);
                if (b == BYTE_CR || b == BYTE_LF) continue;
                h = djb2_next(djb2_next(HASH_SEED, a), b);
                rr = int'((64'(target) - h * 64'd33) % 64'(TBL_SLOTS));
                if (rr < 128) c = 8'(rr);
                else if (rr >= TBL_SLOTS - 128) c = 8'(rr - TBL_SLOTS + 256);
                else continue;
                if (c == BYTE_CR || c == BYTE_LF) continue;
                if (int'(djb2_next(h, c) % 64'(TBL_SLOTS)) != target) continue;
                ln.len = 3;
                ln.txt[0] = a;
                ln.txt[1] = b;
                ln.txt[2] = c;
                crowd.push_back(ln);
            end
        end

        start_n = pending.size();
        crowd_idx = 0;
        while (pending.size() - start_n < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || history.size() == 0) begin
                ln = rand_line();
                queue_line(ln, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
                if (history.size() < 64) history.push_back(ln);
                else history[$urandom_range(0, 63)] = ln;
            end else if (pick < 65) begin
                queue_line(history[$urandom_range(0, history.size() - 1)],
                           1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end else if (pick < 80 && crowd.size() != 0) begin
                queue_line(crowd[crowd_idx % crowd.size()], 1'($urandom_range(0, 1)),
                           1'b0, 1'b0);
                crowd_idx++;
            end else if (pick < 90) begin
                ln = rand_line();
                if (ln.len == 0) ln.len = 1;
                for (int k = 0; k < ln.len; k++)
                    queue_data(ln.txt[k], (k == ln.len - 1), draw_gap());
            end else if (pick < 95) begin
                queue_line(rand_line(), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
            end else if (pick < 97) begin
                queue_clear(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                queue_data(BYTE_LF, 1'($urandom_range(0, 1)), draw_gap());
            end
        end

        queue_clear(8'hFF, 1'b1);
        queue_line(rand_line(), 1'b1, 1'b0, 1'b0);

        total_items = pending.size();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (fed_count < total_items) @(posedge i_clk);
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ldhf_pkg.sv
hw/rtl/ldhf_ram.sv
hw/rtl/ldhf_front.sv
hw/rtl/ldhf_back.sv
hw/rtl/line_dedup_hash_filter_top.sv
verif/tb_top.sv
